/* hdl/psg_pkg.sv */
// Package with shared constants and the attenuation table of the sound generator.
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;
  localparam int PHASE_FRACTION_BITS = 24;
  localparam int TONE_CHANNELS       = 3;
  localparam int SCALE_W             = 32;
  localparam int DIV_W               = 10;
  localparam int SUM_W               = 19;
  localparam int MAG_W               = 18;
  localparam int RECIP_SHIFT         = 21;
  localparam int RECIP_W             = 19;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(419431);
  localparam logic [14:0] LFSR_SEED  = 15'h4000;
  localparam logic [31:0] STEP_SCALE_RESET = 32'd47554790;
  localparam logic [1:0]  NOISE_CH   = 2'd3;
  localparam logic [1:0]  RATE_TONE2 = 2'd3;

  function automatic logic [15:0] amp_q15(input logic [3:0] att);
    logic [15:0] a;
    case (att)
      4'd0:    a = 16'd32768;
      4'd1:    a = 16'd26028;
      4'd2:    a = 16'd20677;
      4'd3:    a = 16'd16423;
      4'd4:    a = 16'd13045;
      4'd5:    a = 16'd10361;
      4'd6:    a = 16'd8231;
      4'd7:    a = 16'd6537;
      4'd8:    a = 16'd5194;
      4'd9:    a = 16'd4125;
      4'd10:   a = 16'd3277;
      4'd11:   a = 16'd2602;
      4'd12:   a = 16'd2068;
      4'd13:   a = 16'd1642;
      4'd14:   a = 16'd1304;
      default: a = 16'd0;
    endcase
    return a;
  endfunction
endpackage
`default_nettype wire

/* hdl/psg_in_if.sv */
// Input channel interface: command and write byte with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] write_byte;
  modport source (output valid, command, write_byte, input ready);
  modport sink (input valid, command, write_byte, output ready);
endinterface
`default_nettype wire

/* hdl/psg_out_if.sv */
// Result channel interface: signed sample with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface psg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

/* hdl/psg_three_tone_noise_synth_core.sv */
// Top level of the three-tone, one-noise sound generator with a shared serial divider.
//
//   channel | dir | signals                         | transfer when
//   in_ch   | in  | command, write_byte             | valid && ready
//   out_ch  | out | sample (Q1.15)                  | valid && ready
//   cfg     | in  | cfg_we, cfg_wdata (step scale)  | cfg_we high
//
// A write byte or a tick command is taken only in S_IDLE. For a tick, each of the
// four channels runs one 32-step restoring division of the step scale through the
// single shared divider, then the mix goes through one multiply for the divide by five.
// Reset (rst_n low, synchronous) restores the control registers but not the datapath.
// A finished sample waits in the output register; a new item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module psg_three_tone_noise_synth_core
  import psg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  psg_in_if.sink            in_ch,
  psg_out_if.source         out_ch,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int PFB   = PHASE_FRACTION_BITS;
  localparam int PSUM_W = SCALE_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_DIV, S_ACC, S_MUL, S_OUT} state_t;

  state_t                   state_r;
  logic [31:0]              scale_r;
  logic [DIV_W-1:0]         tone_div_r [TONE_CHANNELS];
  logic [3:0]               att_r [4];
  logic [2:0]               noise_ctl_r;
  logic [1:0]               latch_ch_r;
  logic                     latch_vol_r;
  logic [14:0]              lfsr_r;
  logic                     noise_lvl_r;
  logic [PFB-1:0]           phase_r [4];
  logic [1:0]               ch_r;
  logic [4:0]               cnt_r;
  logic [DIV_W-1:0]         rem_r;
  logic [SCALE_W-1:0]       quo_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     neg_r;
  logic [MAG_W+RECIP_W-1:0] prod_r;
  logic                     out_valid_r;
  logic signed [15:0]       sample_r;

  // Divider datapath.
  logic [DIV_W-1:0]  div_sel;
  logic [DIV_W:0]    shifted;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;
  always_comb begin
    if (ch_r != NOISE_CH) begin
      div_sel = tone_div_r[ch_r];
    end else if (noise_ctl_r[1:0] == RATE_TONE2) begin
      div_sel = tone_div_r[2];
    end else begin
      div_sel = DIV_W'(16) << noise_ctl_r[1:0];
    end
    shifted = {rem_r, quo_r[SCALE_W-1]};
    ge      = shifted >= {1'b0, div_sel};
    rem_nxt = ge ? DIV_W'(shifted - {1'b0, div_sel}) : shifted[DIV_W-1:0];
  end

  // Phase update and level for the channel that just finished dividing.
  logic [PSUM_W-1:0]        psum;
  logic                     wrap;
  logic [14:0]              lfsr_nxt;
  logic                     lvl;
  logic [15:0]              amp;
  logic signed [SUM_W-1:0]  term;
  always_comb begin
    psum     = PSUM_W'(phase_r[ch_r]) + PSUM_W'(quo_r);
    wrap     = |psum[PSUM_W-1:PFB];
    lfsr_nxt = {(noise_ctl_r[2] ? (lfsr_r[0] ^ lfsr_r[1]) : lfsr_r[0]), lfsr_r[14:1]};
    if (ch_r == NOISE_CH) begin
      lvl = wrap ? lfsr_nxt[0] : noise_lvl_r;
    end else begin
      lvl = !psum[PFB-1];
    end
    amp  = amp_q15(att_r[ch_r]);
    term = lvl ? SUM_W'(amp) : -SUM_W'(amp);
  end

  // Rounded divide by five through a reciprocal multiply.
  logic [MAG_W-1:0] mag;
  logic [15:0]      q;
  always_comb begin
    mag = sum_r[SUM_W-1] ? MAG_W'(-sum_r) + MAG_W'(2) : MAG_W'(sum_r) + MAG_W'(2);
    q   = prod_r[RECIP_SHIFT +: 16];
  end

  // Register write decode.
  logic [1:0] w_ch;
  logic       w_vol;
  logic [7:0] b;
  always_comb begin
    b     = in_ch.write_byte;
    w_ch  = b[7] ? b[6:5] : latch_ch_r;
    w_vol = b[7] ? b[4] : latch_vol_r;
  end

  logic [DIV_W-1:0] tone_w;
  always_comb begin
    if (w_ch == NOISE_CH) begin
      tone_w = '0;
    end else if (b[7]) begin
      tone_w = {tone_div_r[w_ch][DIV_W-1:4], b[3:0]};
    end else begin
      tone_w = {b[5:0], tone_div_r[w_ch][3:0]};
    end
    if (tone_w == '0) tone_w = DIV_W'(1);
  end

  wire in_xfer  = in_ch.valid && in_ch.ready;
  wire out_xfer = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= STEP_SCALE_RESET;
      for (int i = 0; i < TONE_CHANNELS; i++) tone_div_r[i] <= DIV_W'(1);
      for (int i = 0; i < 4; i++) begin
        att_r[i]   <= 4'hF;
        phase_r[i] <= '0;
      end
      noise_ctl_r <= '0;
      latch_ch_r  <= '0;
      latch_vol_r <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      noise_lvl_r <= 1'b0;
      ch_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) scale_r <= cfg_wdata;
      // In S_OUT the output register is reloaded in the cycle its sample is taken.
      if (out_xfer && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.command) begin
              ch_r    <= '0;
              sum_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              latch_ch_r  <= w_ch;
              latch_vol_r <= w_vol;
              if (w_vol) begin
                att_r[w_ch] <= b[3:0];
              end else if (w_ch == NOISE_CH) begin
                noise_ctl_r <= b[2:0];
                lfsr_r      <= LFSR_SEED;
              end else begin
                tone_div_r[w_ch] <= tone_w;
              end
            end
          end
        end
        S_LOAD: begin
          rem_r   <= '0;
          quo_r   <= scale_r;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[SCALE_W-2:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_ACC;
        end
        S_ACC: begin
          phase_r[ch_r] <= psum[PFB-1:0];
          sum_r         <= sum_r + term;
          if (ch_r == NOISE_CH) begin
            if (wrap) begin
              lfsr_r      <= lfsr_nxt;
              noise_lvl_r <= lfsr_nxt[0];
            end
            state_r <= S_MUL;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_LOAD;
          end
        end
        S_MUL: begin
          prod_r  <= mag * RECIP_FIVE;
          neg_r   <= sum_r[SUM_W-1];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            sample_r    <= neg_r ? -$signed(q) : $signed(q);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;

  // The noise register can never fall into the all-zero lockup state.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != '0)
    else $error("noise shift register is zero");

  // A zero tone divisor is always replaced by one.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tone_div_r[0] != '0 && tone_div_r[1] != '0 && tone_div_r[2] != '0)
    else $error("tone divisor is zero");

  // A register write byte never produces a sample.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_ch.command) |=> !$rose(out_valid_r))
    else $error("sample produced by a write byte");

  // The divider only runs with a nonzero divisor.
  a_div_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> div_sel != '0)
    else $error("division by zero");
endmodule
`default_nettype wire
